// File: rtl/lbmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbmm_pkg
// Shared types and constants of the LED blink and override mask mixer.
// ----------------------------------------------------------------------------
package lbmm_pkg;

  localparam int unsigned LED_W      = 64;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned ELAPSED_W  = MS_W + 1;
  localparam int unsigned SLOTS      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = LED_W;

  localparam logic [MS_W-1:0] SLOW_PERIOD_RST = MS_W'(500);
  localparam logic [MS_W-1:0] FAST_PERIOD_RST = MS_W'(125);

  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_ADD       = 2'd1,
    MODE_CLEAR     = 2'd2,
    MODE_TIMER_RST = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONSTANT_MASK = 3'd0,
    REG_SLOW_MASK0    = 3'd1,
    REG_SLOW_MASK1    = 3'd2,
    REG_FAST_MASK0    = 3'd3,
    REG_FAST_MASK1    = 3'd4,
    REG_SLOW_PERIOD   = 3'd5,
    REG_FAST_PERIOD   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LED_W-1:0] override_mask;
    logic [MS_W-1:0]  override_ms;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0] current_leds;
    logic [LED_W-1:0] other_phase_leds;
    logic             override_dropped;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/led_blink_mask_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_mask_mixer
// Mixes a constant LED mask, two blink masks (slow and fast) and up to eight
// timed overrides into the mask to drive, plus the opposite-phase mask.
// ----------------------------------------------------------------------------
//  channel   ports                         direction
//  input     in_valid/in_ready/in_data     command transaction in
//  result    out_valid/out_ready/out_data  one mask result per command
//  config    cfg_we/cfg_index/cfg_data     register write, no read-back
//
//  One command per cycle if not stalled: timers and override slots update in
//  the accept cycle and the result lands in the output register on the same
//  edge. The output register holds a result until taken; a new command is
//  taken whenever that register is empty or being emptied in the same cycle.
//  Reset (rst_n, synchronous) frees all slots and clears the timers.
// ----------------------------------------------------------------------------
module led_blink_mask_mixer (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire lbmm_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output lbmm_pkg::out_item_t               out_data,
  input  wire                               cfg_we,
  input  wire [lbmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [lbmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lbmm_pkg::*;

  // configuration
  logic [LED_W-1:0] const_mask_r, slow_mask0_r, slow_mask1_r;
  logic [LED_W-1:0] fast_mask0_r, fast_mask1_r;
  logic [MS_W-1:0]  slow_period_r, fast_period_r;

  // timers
  logic [ELAPSED_W-1:0] slow_elapsed_r, slow_elapsed_nxt;
  logic [ELAPSED_W-1:0] fast_elapsed_r, fast_elapsed_nxt;
  logic                 slow_phase_r, slow_phase_nxt;
  logic                 fast_phase_r, fast_phase_nxt;

  // override slots
  logic [LED_W-1:0] slot_mask_r      [SLOTS];
  logic [LED_W-1:0] slot_mask_nxt    [SLOTS];
  logic [MS_W-1:0]  slot_remain_r    [SLOTS];
  logic [MS_W-1:0]  slot_remain_nxt  [SLOTS];
  logic [SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic                 accept;
  logic                 placed;
  logic                 dropped;
  logic [ELAPSED_W-1:0] slow_inc, fast_inc;
  logic [LED_W-1:0]     live;
  logic [LED_W-1:0]     slow_now, slow_other, fast_now, fast_other;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slow_inc = slow_elapsed_r + ELAPSED_W'(1);
  assign fast_inc = fast_elapsed_r + ELAPSED_W'(1);

  always_comb begin
    slow_elapsed_nxt = slow_elapsed_r;
    fast_elapsed_nxt = fast_elapsed_r;
    slow_phase_nxt   = slow_phase_r;
    fast_phase_nxt   = fast_phase_r;
    slot_valid_nxt   = slot_valid_r;
    placed           = 1'b0;
    dropped          = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_mask_nxt[i]   = slot_mask_r[i];
      slot_remain_nxt[i] = slot_remain_r[i];
    end
    unique case (mode_t'(in_data.mode))
      MODE_TICK: begin
        if (slow_inc > {1'b0, slow_period_r}) begin
          slow_phase_nxt   = !slow_phase_r;
          slow_elapsed_nxt = '0;
        end else begin
          slow_elapsed_nxt = slow_inc;
        end
        if (fast_inc > {1'b0, fast_period_r}) begin
          fast_phase_nxt   = !fast_phase_r;
          fast_elapsed_nxt = '0;
        end else begin
          fast_elapsed_nxt = fast_inc;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid_r[i]) begin
            if (slot_remain_r[i] == '0) begin
              slot_valid_nxt[i] = 1'b0;
            end else begin
              slot_remain_nxt[i] = slot_remain_r[i] - MS_W'(1);
            end
          end
        end
      end
      MODE_ADD: begin
        // lowest free slot wins
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_valid_r[i] && !placed) begin
            slot_mask_nxt[i]   = in_data.override_mask;
            slot_remain_nxt[i] = in_data.override_ms;
            slot_valid_nxt[i]  = 1'b1;
            placed             = 1'b1;
          end
        end
        dropped = !placed;
      end
      MODE_CLEAR: begin
        slot_valid_nxt = '0;
      end
      MODE_TIMER_RST: begin
        slow_elapsed_nxt = '0;
        fast_elapsed_nxt = '0;
        slow_phase_nxt   = 1'b0;
        fast_phase_nxt   = 1'b0;
      end
    endcase
  end

  always_comb begin
    live = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid_nxt[i]) begin
        live = live | slot_mask_nxt[i];
      end
    end
    slow_now   = slow_phase_nxt ? slow_mask1_r : slow_mask0_r;
    slow_other = slow_phase_nxt ? slow_mask0_r : slow_mask1_r;
    fast_now   = fast_phase_nxt ? fast_mask1_r : fast_mask0_r;
    fast_other = fast_phase_nxt ? fast_mask0_r : fast_mask1_r;
    out_data_nxt.current_leds     = const_mask_r | slow_now | fast_now | live;
    out_data_nxt.other_phase_leds = const_mask_r | slow_other | fast_other | live;
    out_data_nxt.override_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_mask_r  <= '0;
      slow_mask0_r  <= '0;
      slow_mask1_r  <= '0;
      fast_mask0_r  <= '0;
      fast_mask1_r  <= '0;
      slow_period_r <= SLOW_PERIOD_RST;
      fast_period_r <= FAST_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONSTANT_MASK: const_mask_r  <= cfg_data;
        REG_SLOW_MASK0:    slow_mask0_r  <= cfg_data;
        REG_SLOW_MASK1:    slow_mask1_r  <= cfg_data;
        REG_FAST_MASK0:    fast_mask0_r  <= cfg_data;
        REG_FAST_MASK1:    fast_mask1_r  <= cfg_data;
        REG_SLOW_PERIOD:   slow_period_r <= cfg_data[MS_W-1:0];
        REG_FAST_PERIOD:   fast_period_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_elapsed_r <= '0;
      fast_elapsed_r <= '0;
      slow_phase_r   <= 1'b0;
      fast_phase_r   <= 1'b0;
      slot_valid_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        slow_elapsed_r <= slow_elapsed_nxt;
        fast_elapsed_r <= fast_elapsed_nxt;
        slow_phase_r   <= slow_phase_nxt;
        fast_phase_r   <= fast_phase_nxt;
        slot_valid_r   <= slot_valid_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slot contents and result payload carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_mask_r[i]   <= slot_mask_nxt[i];
        slot_remain_r[i] <= slot_remain_nxt[i];
      end
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire
